@@ rtl/core/cca_pkg.sv @@
package cca_pkg;

    localparam int LINK_W              = 28;
    localparam int CFG_W               = 12;
    localparam int DEFAULT_TABLE_DEPTH = 4096;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [1:0]        t_req_type;
    typedef logic [1:0]        t_status;
    typedef logic [CFG_W-1:0]  t_cfg;

    // request kinds
    localparam t_req_type REQ_READ  = 2'd0;
    localparam t_req_type REQ_WRITE = 2'd1;
    localparam t_req_type REQ_ALLOC = 2'd2;
    localparam t_req_type REQ_FREE  = 2'd3;

    // result status
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    localparam t_link END_CHAIN  = 28'hFFF_FFF8;
    localparam t_link FIRST_DATA = 28'd2;
    localparam t_cfg  CIU_RESET  = 12'd4094;

endpackage

@@ rtl/core/cca_if.sv @@
interface cca_req_if;
    import cca_pkg::*;

    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_link     cluster;
    t_link     link_value;

    modport source (output valid, output req_type, output cluster, output link_value,
                    input ready);
    modport sink   (input valid, input req_type, input cluster, input link_value,
                    output ready);
endinterface

interface cca_rsp_if;
    import cca_pkg::*;

    logic    valid;
    logic    ready;
    t_link   result_cluster;
    t_status status;

    modport source (output valid, output result_cluster, output status, input ready);
    modport sink   (input valid, input result_cluster, input status, output ready);
endinterface

@@ rtl/core/cluster_chain_allocator.sv @@
// channel    | dir | handshake      | payload
// -----------+-----+----------------+-------------------------------------------
// i_req      | in  | valid / ready  | req_type, cluster, link_value
// o_rsp      | out | valid / ready  | result_cluster, status
// cfg        | in  | i_cfg_we       | i_cfg_wdata (clusters_in_use)
//
// read and write need one table access each; allocate scans entries in order and,
// with a predecessor, links it; free walks the chain; the link memory (one write
// port, one registered read port) sets the walk speed, one entry read per cycle
// reset clears all TABLE_DEPTH entries in one pass, no item is taken meanwhile
// one item is worked at a time; the next item is taken while a result waits in
// the output register, and its result holds until that register drains
module cluster_chain_allocator #(
    parameter int TABLE_DEPTH = cca_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cca_req_if.sink             i_req,
    cca_rsp_if.source           o_rsp,
    input  logic                i_cfg_we,
    input  cca_pkg::t_cfg       i_cfg_wdata
);
    import cca_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW    = $clog2(TABLE_DEPTH + 1);
    // width for scan-bound compares: holds clusters_in_use+2 and the depth
    localparam int CW    = (DW > CFG_W + 1) ? DW : CFG_W + 1;

    localparam t_link            DEPTH_L  = LINK_W'(TABLE_DEPTH);
    localparam logic [AW-1:0]    LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [AW-1:0]    FIRST_IX = AW'(FIRST_DATA);
    localparam logic [CW-1:0]    DEPTH_C  = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0]    FIRST_C  = CW'(FIRST_DATA);

    // controller states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // link table, single write port, one registered read port
    t_link         r_link_mem [TABLE_DEPTH];
    t_link         r_rdata;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;          // clear address, scan cluster, free cursor
    logic [CW-1:0] r_limit, n_limit;      // scan bound
    logic          r_pred_v, n_pred_v;
    logic [AW-1:0] r_pred_addr, n_pred_addr;
    logic          r_fwd_zero, n_fwd_zero; // read hits the entry zeroed last cycle
    t_link         r_res, n_res;
    t_status       r_stat, n_stat;
    t_cfg          r_ciu;

    logic          r_out_valid;
    t_link         r_out_cluster;
    t_status       r_out_status;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_link         mem_wdata;

    logic          out_take;
    logic          in_range;
    t_link         rd_eff;
    logic [CW-1:0] lim_sum, lim;

    assign out_take = !r_out_valid || o_rsp.ready;
    assign in_range = i_req.cluster < DEPTH_L;
    assign rd_eff   = r_fwd_zero ? '0 : r_rdata;
    assign lim_sum  = CW'(r_ciu) + FIRST_C;
    assign lim      = (lim_sum < DEPTH_C) ? lim_sum : DEPTH_C;

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_cluster = r_out_cluster;
    assign o_rsp.status         = r_out_status;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_limit     = r_limit;
        n_pred_v    = r_pred_v;
        n_pred_addr = r_pred_addr;
        n_fwd_zero  = 1'b0;
        n_res       = r_res;
        n_stat      = r_stat;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_ptr;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_ptr == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end

            S_IDLE: begin
                if (i_req.valid) begin
                    n_res   = '0;
                    n_stat  = ST_OK;
                    n_state = S_DONE;
                    case (i_req.req_type)
                        REQ_READ: begin
                            if (in_range) begin
                                mem_re    = 1'b1;
                                mem_raddr = i_req.cluster[AW-1:0];
                                n_state   = S_RD;
                            end else begin
                                n_stat = ST_RANGE;
                            end
                        end
                        REQ_WRITE: begin
                            if (in_range) begin
                                mem_we    = 1'b1;
                                mem_waddr = i_req.cluster[AW-1:0];
                                mem_wdata = i_req.link_value;
                            end else begin
                                n_stat = ST_RANGE;
                            end
                        end
                        REQ_ALLOC: begin
                            n_pred_v    = (i_req.cluster != '0);
                            n_pred_addr = i_req.cluster[AW-1:0];
                            n_limit     = lim;
                            if (i_req.cluster != '0 && !in_range) begin
                                n_stat = ST_RANGE;
                            end else if (lim <= FIRST_C) begin
                                n_stat = ST_FULL;
                            end else begin
                                // first-fit scan starts at the first data cluster
                                mem_re    = 1'b1;
                                mem_raddr = FIRST_IX;
                                n_ptr     = FIRST_IX;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            // free chain: no chain unless start is a data link
                            if (i_req.cluster < FIRST_DATA || i_req.cluster >= END_CHAIN) begin
                                n_stat = ST_OK;
                            end else if (!in_range) begin
                                n_stat = ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = i_req.cluster[AW-1:0];
                                n_ptr     = i_req.cluster[AW-1:0];
                                n_state   = S_FREE;
                            end
                        end
                    endcase
                end
            end

            S_RD: begin
                n_res   = r_rdata;
                n_state = S_DONE;
            end

            S_SCAN: begin
                if (r_rdata == '0) begin
                    // free entry found: mark end of chain, then link predecessor
                    mem_we    = 1'b1;
                    mem_wdata = END_CHAIN;
                    n_res     = LINK_W'(r_ptr);
                    n_state   = r_pred_v ? S_LINK : S_DONE;
                end else if (CW'(r_ptr) + CW'(1) >= r_limit) begin
                    n_stat  = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr + AW'(1);
                    n_ptr     = r_ptr + AW'(1);
                end
            end

            S_LINK: begin
                // runs after the end-of-chain mark, so a self link wins
                mem_we    = 1'b1;
                mem_waddr = r_pred_addr;
                mem_wdata = LINK_W'(r_ptr);
                n_state   = S_DONE;
            end

            S_FREE: begin
                mem_we = 1'b1;
                if (rd_eff < FIRST_DATA || rd_eff >= END_CHAIN) begin
                    n_state = S_DONE;
                end else if (rd_eff >= DEPTH_L) begin
                    // chain leaves the table
                    n_stat  = ST_RANGE;
                    n_state = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = rd_eff[AW-1:0];
                    n_ptr      = rd_eff[AW-1:0];
                    // read sees old data while this entry is zeroed
                    n_fwd_zero = (rd_eff[AW-1:0] == r_ptr);
                end
            end

            S_DONE: begin
                if (out_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_link_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_fwd_zero  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ciu       <= CIU_RESET;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_fwd_zero <= n_fwd_zero;
            if (i_cfg_we) begin
                r_ciu <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_take) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_limit     <= n_limit;
        r_pred_v    <= n_pred_v;
        r_pred_addr <= n_pred_addr;
        r_res       <= n_res;
        r_stat      <= n_stat;
        if (r_state == S_DONE && out_take) begin
            r_out_cluster <= r_res;
            r_out_status  <= r_stat;
        end
    end

endmodule

@@ rtl/core/cca_checker.sv @@
module cca_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  logic             i_rsp_valid,
    input  logic             i_rsp_ready,
    input  cca_pkg::t_link   i_rsp_cluster,
    input  cca_pkg::t_status i_rsp_status
);
    import cca_pkg::*;

    // items taken but not yet answered
    logic [1:0] r_cnt, n_cnt;
    logic       req_acc, rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (req_acc && !rsp_acc) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rsp_acc && !req_acc) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_cnt != 2'd0)
        else $error("result with no item outstanding");

    a_two_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |-> r_cnt != 2'd2)
        else $error("item taken while two are outstanding");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_OK) |-> i_rsp_cluster == '0)
        else $error("failed result carries a cluster");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_cluster) && $stable(i_rsp_status)))
        else $error("stalled result changed");

endmodule

bind cluster_chain_allocator cca_checker u_cca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_cluster (o_rsp.result_cluster),
    .i_rsp_status  (o_rsp.status)
);
